FILE: rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Operation codes, sequencer state codes and widths shared by the RTL files.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

   localparam int NUM_W = 32;
   localparam int DEN_W = 31;
   localparam int WIDE_W = 64;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_GT  = 3'd4;
   localparam logic [2:0] OP_LT  = 3'd5;
   localparam logic [2:0] OP_EQ  = 3'd6;
   localparam logic [2:0] OP_NE  = 3'd7;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_SUM  = 3'd2;
   localparam logic [2:0] S_GCD  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

endpackage

`default_nettype wire

FILE: rtl/rau_if.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit channels
// Valid/ready request and response channels with their payload fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface rau_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         req_type;
   logic signed [31:0] a_num;
   logic [30:0]        a_den;
   logic signed [31:0] b_num;
   logic [30:0]        b_den;

   modport source (output valid, req_type, a_num, a_den, b_num, b_den, input ready);
   modport sink (input valid, req_type, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] res_num;
   logic [62:0]        res_den;
   logic               flag;
   logic               status;

   modport source (output valid, res_num, res_den, flag, status, input ready);
   modport sink (input valid, res_num, res_den, flag, status, output ready);
endinterface

`default_nettype wire

FILE: rtl/rau_mul.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit multiplier
// Signed 32 x 32 multiply with a registered 64-bit product.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_mul (
   input  logic                              clock,
   input  logic signed [rau_pkg::NUM_W-1:0]  mul_a,
   input  logic signed [rau_pkg::NUM_W-1:0]  mul_b,
   output logic signed [rau_pkg::WIDE_W-1:0] mul_p
);
   import rau_pkg::*;

   logic signed [WIDE_W-1:0] prod_ff;
   logic signed [WIDE_W-1:0] prod_in;

   assign prod_in = WIDE_W'(mul_a * mul_b);
   assign mul_p = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

FILE: rtl/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides or compares two fractions; arithmetic
// results are reduced by a binary gcd and two restoring divisions.
// ----------------------------------------------------------------------------
// Sequence: every operation forms its cross products on the multiplier;
// arithmetic then runs a binary gcd and two restoring divisions on one
// shared 64-bit subtractor.
// Throughput: one transaction at a time; ready only while the sequencer idles.
// Reset: synchronous, clears the sequencer and the response valid.
`default_nettype none

module rational_arithmetic_unit (
   input  logic clock,
   input  logic reset,
   rau_req_if.sink   req_chan,
   rau_rsp_if.source rsp_chan
);
   import rau_pkg::*;

   logic [2:0]         state_ff, state_in;
   logic [2:0]         op_ff, op_in;
   logic signed [31:0] an_ff, an_in, bn_ff, bn_in;
   logic [30:0]        ad_ff, ad_in, bd_ff, bd_in;
   logic [1:0]         mcnt_ff, mcnt_in;
   logic signed [63:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic               neg_ff, neg_in;
   logic [63:0]        u_ff, u_in, v_ff, v_in;
   logic [5:0]         k_ff, k_in;
   logic [63:0]        g_ff, g_in;
   logic [63:0]        dm_ff, dm_in;
   logic [63:0]        q_ff, q_in, r_ff, r_in, qn_ff, qn_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               phase_ff, phase_in;
   logic signed [63:0] fnum_ff, fnum_in;
   logic [62:0]        fden_ff, fden_in;
   logic               fflag_ff, fflag_in, fstat_ff, fstat_in;
   logic signed [63:0] rnum_ff, rnum_in;
   logic [62:0]        rden_ff, rden_in;
   logic               rflag_ff, rflag_in, rstat_ff, rstat_in;
   logic               rvalid_ff, rvalid_in;

   logic signed [31:0] mx, my;
   logic signed [63:0] prod;
   logic [63:0]        sa, sb;
   logic [64:0]        diff;
   logic [63:0]        rs;
   logic signed [63:0] addend, nsum, dsel, nn, dd;
   logic               sub_op;

   rau_mul u_mul (
      .clock (clock),
      .mul_a (mx),
      .mul_b (my),
      .mul_p (prod)
   );

   // operand selection for the three cross products
   always_comb begin
      case (mcnt_ff)
         2'd0: begin
            mx = an_ff;
            my = (op_ff == OP_MUL) ? bn_ff : $signed({1'b0, bd_ff});
         end
         2'd1: begin
            mx = bn_ff;
            my = $signed({1'b0, ad_ff});
         end
         default: begin
            mx = $signed({1'b0, ad_ff});
            my = $signed({1'b0, bd_ff});
         end
      endcase
   end

   // shared subtractor for gcd and division steps
   assign rs = {r_ff[62:0], q_ff[63]};
   assign sa = (state_ff == S_GCD) ? u_ff : rs;
   assign sb = (state_ff == S_GCD) ? v_ff : g_ff;
   assign diff = {1'b0, sa} - {1'b0, sb};

   assign sub_op = (op_ff == OP_SUB);
   assign addend = (op_ff == OP_ADD || op_ff == OP_SUB) ? (sub_op ? ~p1_ff : p1_ff) : 64'sd0;
   assign nsum = p0_ff + addend + {63'd0, sub_op};
   assign dsel = (op_ff == OP_DIV) ? p1_ff : p2_ff;
   assign nn = dsel[63] ? -nsum : nsum;
   assign dd = dsel[63] ? -dsel : dsel;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rvalid_ff;
   assign rsp_chan.res_num = rnum_ff;
   assign rsp_chan.res_den = rden_ff;
   assign rsp_chan.flag = rflag_ff;
   assign rsp_chan.status = rstat_ff;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      an_in = an_ff;
      bn_in = bn_ff;
      ad_in = ad_ff;
      bd_in = bd_ff;
      mcnt_in = mcnt_ff;
      p0_in = p0_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      neg_in = neg_ff;
      u_in = u_ff;
      v_in = v_ff;
      k_in = k_ff;
      g_in = g_ff;
      dm_in = dm_ff;
      q_in = q_ff;
      r_in = r_ff;
      qn_in = qn_ff;
      cnt_in = cnt_ff;
      phase_in = phase_ff;
      fnum_in = fnum_ff;
      fden_in = fden_ff;
      fflag_in = fflag_ff;
      fstat_in = fstat_ff;
      rnum_in = rnum_ff;
      rden_in = rden_ff;
      rflag_in = rflag_ff;
      rstat_in = rstat_ff;
      rvalid_in = rvalid_ff;

      if (rvalid_ff && rsp_chan.ready) begin
         rvalid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in = req_chan.req_type;
               an_in = req_chan.a_num;
               bn_in = req_chan.b_num;
               ad_in = req_chan.a_den;
               bd_in = req_chan.b_den;
               mcnt_in = 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // the multiplier registers its product, so each step takes the product of the previous step
            if (mcnt_ff == 2'd1) p0_in = prod;
            if (mcnt_ff == 2'd2) p1_in = prod;
            if (mcnt_ff == 2'd3) begin
               p2_in = prod;
               state_in = S_SUM;
            end
            mcnt_in = mcnt_ff + 2'd1;
         end
         S_SUM: begin
            fnum_in = 64'sd0;
            fden_in = 63'd1;
            fflag_in = 1'b0;
            fstat_in = 1'b0;
            state_in = S_DONE;
            case (op_ff)
               OP_GT: fflag_in = (p0_ff > p1_ff);
               OP_LT: fflag_in = (p0_ff < p1_ff);
               OP_EQ: fflag_in = (an_ff == bn_ff) && (ad_ff == bd_ff);
               OP_NE: fflag_in = (an_ff != bn_ff) || (ad_ff != bd_ff);
               default: begin
                  if ((op_ff == OP_DIV && bn_ff == 32'sd0) || dsel == 64'sd0) begin
                     fstat_in = 1'b1;
                  end else begin
                     neg_in = nn[63];
                     u_in = nn[63] ? 64'(-nn) : 64'(nn);
                     dm_in = 64'(dd);
                     v_in = 64'(dd);
                     k_in = 6'd0;
                     state_in = S_GCD;
                  end
               end
            endcase
         end
         S_GCD: begin
            if (u_ff == 64'd0) begin
               g_in = v_ff << k_ff;
               q_in = neg_ff ? 64'(-$signed(nn)) : 64'(nn);
               // rebuild magnitude from the stored products
               r_in = 64'd0;
               cnt_in = 6'd0;
               phase_in = 1'b0;
               state_in = S_DIV;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_in = u_ff >> 1;
               v_in = v_ff >> 1;
               k_in = k_ff + 6'd1;
            end else if (!u_ff[0]) begin
               u_in = u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_in = v_ff >> 1;
            end else if (!diff[64]) begin
               u_in = diff[63:0];
            end else begin
               v_in = u_ff;
               u_in = -diff[63:0];
            end
         end
         S_DIV: begin
            if (!diff[64]) begin
               r_in = diff[63:0];
               q_in = {q_ff[62:0], 1'b1};
            end else begin
               r_in = rs;
               q_in = {q_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               if (!phase_ff) begin
                  qn_in = q_in;
                  q_in = dm_ff;
                  r_in = 64'd0;
                  phase_in = 1'b1;
               end else begin
                  fnum_in = neg_ff ? -$signed(qn_ff) : $signed(qn_ff);
                  fden_in = q_in[62:0];
                  fflag_in = 1'b0;
                  fstat_in = 1'b0;
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            // hold until the response register is free
            if (!rvalid_ff || rsp_chan.ready) begin
               rnum_in = fnum_ff;
               rden_in = fden_ff;
               rflag_in = fflag_ff;
               rstat_in = fstat_ff;
               rvalid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rvalid_ff <= rvalid_in;
      end
      op_ff <= op_in;
      an_ff <= an_in;
      bn_ff <= bn_in;
      ad_ff <= ad_in;
      bd_ff <= bd_in;
      mcnt_ff <= mcnt_in;
      p0_ff <= p0_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      neg_ff <= neg_in;
      u_ff <= u_in;
      v_ff <= v_in;
      k_ff <= k_in;
      g_ff <= g_in;
      dm_ff <= dm_in;
      q_ff <= q_in;
      r_ff <= r_in;
      qn_ff <= qn_in;
      cnt_ff <= cnt_in;
      phase_ff <= phase_in;
      fnum_ff <= fnum_in;
      fden_ff <= fden_in;
      fflag_ff <= fflag_in;
      fstat_ff <= fstat_in;
      rnum_ff <= rnum_in;
      rden_ff <= rden_in;
      rflag_ff <= rflag_in;
      rstat_ff <= rstat_in;
   end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives fractions and operation codes through the request channel, predicts
// each reduced result or comparison outcome, and checks every response in
// order under varying sender and receiver idling, including a long stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import rau_pkg::*;

   typedef struct {
      logic signed [63:0] num;
      logic [62:0]        den;
      logic               flag;
      logic               status;
   } frac_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rau_req_if req_chan ();
   rau_rsp_if rsp_chan ();

   rational_arithmetic_unit uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always #5 clock = ~clock;

   frac_result_type expected_results[$];
   int mismatch_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off = 1'b0;
   int hold_cycles = 0;
   int op_seen[8];

   task automatic report(input string what);
      $display("MISMATCH [%0d]: %s", checked_count, what);
      mismatch_count++;
   endtask

   function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic frac_result_type reduce_frac(input longint n, input longint d);
      frac_result_type r;
      logic [63:0] mag, dm, g;
      bit neg;
      r = '{num: 64'sd0, den: 63'd1, flag: 1'b0, status: 1'b0};
      if (d == 0) begin
         r.status = 1'b1;
         return r;
      end
      if (d < 0) begin
         n = -n;
         d = -d;
      end
      neg = n < 0;
      mag = neg ? -n : n;
      dm = d;
      g = gcd64(mag, dm);
      mag = mag / g;
      dm = dm / g;
      r.num = neg ? -$signed(mag) : $signed(mag);
      r.den = dm[62:0];
      return r;
   endfunction

   function automatic frac_result_type predict_fraction(input logic [2:0] op,
         input logic signed [31:0] an_f, input logic [30:0] ad_f,
         input logic signed [31:0] bn_f, input logic [30:0] bd_f);
      frac_result_type r;
      longint an, ad, bn, bd;
      an = an_f;
      ad = {33'd0, ad_f};
      bn = bn_f;
      bd = {33'd0, bd_f};
      r = '{num: 64'sd0, den: 63'd1, flag: 1'b0, status: 1'b0};
      case (op)
         OP_ADD: r = reduce_frac(an * bd + bn * ad, ad * bd);
         OP_SUB: r = reduce_frac(an * bd - bn * ad, ad * bd);
         OP_MUL: r = reduce_frac(an * bn, ad * bd);
         OP_DIV: begin
            if (bn == 0) r.status = 1'b1;
            else r = reduce_frac(an * bd, ad * bn);
         end
         OP_GT: r.flag = (an * bd) > (bn * ad);
         OP_LT: r.flag = (an * bd) < (bn * ad);
         OP_EQ: r.flag = (an == bn) && (ad == bd);
         default: r.flag = (an != bn) || (ad != bd);
      endcase
      return r;
   endfunction

   // drop valid only while idling so back-to-back transactions keep it high
   task automatic send_fraction_op(input logic [2:0] op, input logic signed [31:0] an,
         input logic [30:0] ad, input logic signed [31:0] bn, input logic [30:0] bd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.req_type <= op;
      req_chan.a_num <= an;
      req_chan.a_den <= ad;
      req_chan.b_num <= bn;
      req_chan.b_den <= bd;
      do @(posedge clock); while (!req_chan.ready);
      expected_results.push_back(predict_fraction(op, an, ad, bn, bd));
      op_seen[op]++;
      sent_count++;
   endtask

   // receiver idling, with an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_off) begin
         rsp_chan.ready <= 1'b0;
         hold_cycles++;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      frac_result_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_results.size() == 0) begin
            report("response with nothing expected");
         end else begin
            e = expected_results.pop_front();
            if (rsp_chan.res_num !== e.num)
               report($sformatf("res_num %0d, expected %0d", rsp_chan.res_num, e.num));
            if (rsp_chan.res_den !== e.den)
               report($sformatf("res_den %0d, expected %0d", rsp_chan.res_den, e.den));
            if (rsp_chan.flag !== e.flag)
               report($sformatf("flag %b, expected %b", rsp_chan.flag, e.flag));
            if (rsp_chan.status !== e.status)
               report($sformatf("status %b, expected %b", rsp_chan.status, e.status));
         end
         checked_count++;
      end
   end

   function automatic logic signed [31:0] rand_num();
      case ($urandom_range(3))
         0: return $signed($urandom_range(20)) - 10;
         1: return $signed($urandom_range(2000)) - 1000;
         default: return $signed($urandom());
      endcase
   endfunction

   function automatic logic [30:0] rand_den();
      case ($urandom_range(3))
         0: return 31'($urandom_range(12, 1));
         1: return 31'($urandom_range(5000, 1));
         default: return 31'($urandom());
      endcase
   endfunction

   task automatic test_directed();
      logic [2:0] op;
      for (int k = 0; k < 8; k++) begin
         op = 3'(k);
         send_fraction_op(op, 32'sh7fffffff, 31'h7fffffff, 32'sh80000001, 31'd1);
      end
      send_fraction_op(OP_ADD, 32'sh80000000, 31'd1, 32'sh80000000, 31'h7fffffff);
      send_fraction_op(OP_MUL, 32'sh80000000, 31'd1, 32'sh80000000, 31'd1);
      send_fraction_op(OP_DIV, 32'sd5, 31'd3, 32'sd0, 31'd7);
      send_fraction_op(OP_ADD, 32'sd1, 31'd0, 32'sd2, 31'd3);
      send_fraction_op(OP_DIV, 32'sd1, 31'd0, 32'sd2, 31'd3);
      send_fraction_op(OP_GT, 32'sd1, 31'd0, 32'sd2, 31'd0);
      send_fraction_op(OP_LT, 32'sd3, 31'd0, 32'sd2, 31'd5);
      send_fraction_op(OP_SUB, 32'sd2, 31'd4, 32'sd3, 31'd6);
      send_fraction_op(OP_EQ, 32'sd1, 31'd2, 32'sd2, 31'd4);
      send_fraction_op(OP_NE, 32'sd1, 31'd2, 32'sd2, 31'd4);
      send_fraction_op(OP_DIV, 32'sd3, 31'd4, 32'sh80000000, 31'd2);
      send_fraction_op(OP_EQ, 32'sd0, 31'd1, 32'sd0, 31'd1);
      send_fraction_op(OP_MUL, 32'sd0, 31'd9, 32'sd5, 31'd3);
   endtask

   task automatic test_random(input int count);
      logic [2:0] op;
      logic signed [31:0] an, bn;
      logic [30:0] ad, bd;
      for (int i = 0; i < count; i++) begin
         op = 3'($urandom_range(7));
         an = rand_num();
         bn = rand_num();
         ad = rand_den();
         bd = rand_den();
         // steer equality and zero cases so they actually occur
         if ($urandom_range(9) == 0) begin
            bn = an;
            bd = ad;
         end
         if ($urandom_range(19) == 0) bn = '0;
         if ($urandom_range(39) == 0) ad = '0;
         send_fraction_op(op, an, ad, bn, bd);
      end
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      hold_cycles = 0;
      send_idle_pct = 0;
      // release the receiver after the long hold so the sender can finish
      fork
         test_random(6);
         begin
            wait (hold_cycles >= 2000);
            hold_off = 1'b0;
         end
      join
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.req_type = OP_ADD;
      req_chan.a_num = '0;
      req_chan.a_den = '0;
      req_chan.b_num = '0;
      req_chan.b_den = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 13;
      recv_idle_pct = 65;
      test_directed();
      test_random(600);
      send_idle_pct = 65;
      recv_idle_pct = 13;
      test_random(600);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(600);
      test_backpressure();
      req_chan.valid <= 1'b0;

      while (expected_results.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("Covered %0d transactions: add %0d sub %0d mul %0d div %0d", sent_count,
               op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
      $display("compare gt %0d lt %0d eq %0d ne %0d; %0d responses checked",
               op_seen[4], op_seen[5], op_seen[6], op_seen[7], checked_count);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #40000000;
      $display("Timeout with %0d responses outstanding", expected_results.size());
      $display("Regression FAIL");
      $finish;
   end
endmodule

`default_nettype wire

FILE: rational_arithmetic_unit.f
rtl/rau_pkg.sv
rtl/rau_if.sv
rtl/rau_mul.sv
rtl/rational_arithmetic_unit.sv
tb/tb.sv
